// ----- rtl/core/lzw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the LZW byte encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

    localparam int CODE_W     = 12;
    localparam int SYM_W      = 8;
    localparam int NFC_W      = CODE_W + 1;
    localparam int TABLE_DEPTH = 1 << CODE_W;
    localparam logic [NFC_W-1:0] FIRST_FREE = NFC_W'(256);

    // Head of a code's child list
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] child;
    } head_t;

    // Dictionary node: the byte that extends its parent, and the next sibling
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic              sib_valid;
        logic [CODE_W-1:0] sib;
    } node_t;

endpackage

// ----- rtl/core/lzw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/lzw_byte_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_byte_encoder
// LZW encoder, one byte per transfer, 12-bit codes. The dictionary is a trie
// held as child lists: a head memory gives each code's first child, a node
// memory gives each code's byte and next sibling.
//
//   channel  signals                          direction
//   in       in_valid in_stall symbol          into block
//            end_of_message
//   out      out_valid out_stall code          out of block
//            last_code
//
// A byte matching the first child of the prefix passes a head read and a node
// compare; each further sibling visited in the node memory (at most 255) adds
// a node compare. A miss adds an emit and the insert states INS_A and INS_B
// after the search (no insert once frozen); an empty child list ends the
// search at the head read. The first byte of a message skips the search. A
// message end adds an emit. Reset clears control state only; root list heads
// are flop valid bits. A stalled output holds the emit state until taken.
// ----------------------------------------------------------------------------
module lzw_byte_encoder
    import lzw_pkg::*;
#(
    parameter int DICT_SIZE = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SYM_W-1:0]  symbol,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CODE_W-1:0] code,
    output logic              last_code
);

    localparam logic [NFC_W-1:0] CODE_LIMIT =
        (DICT_SIZE < TABLE_DEPTH) ? NFC_W'(DICT_SIZE) : NFC_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_NODE, S_MISS_OUT, S_INS_A, S_INS_B, S_EOM_OUT
    } state_t;

    state_t            state_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              eom_reg;
    logic [CODE_W-1:0] prefix_reg;
    logic              pvalid_reg;
    logic [NFC_W-1:0]  nfc_reg;
    logic [CODE_W-1:0] cur_reg;
    head_t             oldhead_reg;
    logic [255:0]      root_valid_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;

    // memory ports
    logic              head_we;
    logic [CODE_W-1:0] head_waddr;
    head_t             head_wdata;
    logic [CODE_W-1:0] head_raddr;
    head_t             head_rdata;
    logic              node_we;
    logic [CODE_W-1:0] node_waddr;
    node_t             node_wdata;
    logic [CODE_W-1:0] node_raddr;
    node_t             node_rdata;

    logic accept;
    logic out_free;
    logic emit;
    logic prefix_root;
    logic head_valid;

    lzw_ram #(.WIDTH($bits(head_t)), .DEPTH(TABLE_DEPTH)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    lzw_ram #(.WIDTH($bits(node_t)), .DEPTH(TABLE_DEPTH)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign last_code = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = ((state_reg == S_MISS_OUT) || (state_reg == S_EOM_OUT)) && out_free;

    // root codes keep their list head valid in flops
    assign prefix_root = (prefix_reg[CODE_W-1:SYM_W] == '0);
    assign head_valid  = prefix_root ? root_valid_reg[prefix_reg[SYM_W-1:0]]
                                     : head_rdata.valid;

    // memory addressing
    always_comb
    begin
        head_raddr = prefix_reg;
        node_raddr = (state_reg == S_HEAD) ? head_rdata.child : node_rdata.sib;
        head_we    = 1'b0;
        head_waddr = prefix_reg;
        head_wdata = '{valid: 1'b1, child: nfc_reg[CODE_W-1:0]};
        node_we    = (state_reg == S_INS_A);
        node_waddr = nfc_reg[CODE_W-1:0];
        node_wdata = '{sym: sym_reg, sib_valid: oldhead_reg.valid,
                       sib: oldhead_reg.child};
        if (state_reg == S_INS_A)
        begin
            head_we = 1'b1;
        end
        else if (state_reg == S_INS_B)
        begin
            head_we    = 1'b1;
            head_waddr = nfc_reg[CODE_W-1:0];
            head_wdata = '{valid: 1'b0, child: '0};
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prefix_reg     <= '0;
            pvalid_reg     <= 1'b0;
            nfc_reg        <= FIRST_FREE;
            root_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            sym_reg        <= '0;
            eom_reg        <= 1'b0;
            cur_reg        <= '0;
            oldhead_reg    <= '0;
            code_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sym_reg <= symbol;
                        eom_reg <= end_of_message;
                        if (!pvalid_reg)
                        begin
                            prefix_reg <= CODE_W'(symbol);
                            pvalid_reg <= 1'b1;
                            state_reg  <= end_of_message ? S_EOM_OUT : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_HEAD;
                        end
                    end
                end
                S_HEAD:
                begin
                    oldhead_reg <= '{valid: head_valid, child: head_rdata.child};
                    cur_reg     <= head_rdata.child;
                    state_reg   <= head_valid ? S_NODE : S_MISS_OUT;
                end
                S_NODE:
                begin
                    if (node_rdata.sym == sym_reg)
                    begin
                        prefix_reg <= cur_reg;
                        state_reg  <= eom_reg ? S_EOM_OUT : S_IDLE;
                    end
                    else if (node_rdata.sib_valid)
                    begin
                        cur_reg <= node_rdata.sib;
                    end
                    else
                    begin
                        state_reg <= S_MISS_OUT;
                    end
                end
                S_MISS_OUT:
                begin
                    if (out_free)
                    begin
                        code_reg      <= prefix_reg;
                        last_reg      <= 1'b0;
                        if (nfc_reg < CODE_LIMIT)
                        begin
                            state_reg <= S_INS_A;
                        end
                        else
                        begin
                            prefix_reg <= CODE_W'(sym_reg);
                            state_reg  <= eom_reg ? S_EOM_OUT : S_IDLE;
                        end
                    end
                end
                S_INS_A:
                begin
                    if (prefix_root)
                    begin
                        root_valid_reg[prefix_reg[SYM_W-1:0]] <= 1'b1;
                    end
                    state_reg <= S_INS_B;
                end
                S_INS_B:
                begin
                    nfc_reg    <= nfc_reg + NFC_W'(1);
                    prefix_reg <= CODE_W'(sym_reg);
                    state_reg  <= eom_reg ? S_EOM_OUT : S_IDLE;
                end
                S_EOM_OUT:
                begin
                    if (out_free)
                    begin
                        code_reg       <= prefix_reg;
                        last_reg       <= 1'b1;
                        prefix_reg     <= '0;
                        pvalid_reg     <= 1'b0;
                        nfc_reg        <= FIRST_FREE;
                        root_valid_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // next free code never passes the limit
    a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg >= FIRST_FREE && nfc_reg <= CODE_LIMIT)
        else $error("next free code out of range");

    // a walked node is always an assigned dictionary code
    a_node_assigned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NODE |-> cur_reg >= CODE_W'(256) &&
                                NFC_W'(cur_reg) < nfc_reg)
        else $error("walked an unassigned code");

    // the held prefix is a literal or an assigned code
    a_prefix_assigned: assert property (@(posedge clk) disable iff (!rst_n)
        pvalid_reg |-> NFC_W'(prefix_reg) < nfc_reg)
        else $error("prefix beyond assigned codes");

    // insertion only follows an emitted miss
    a_insert_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_A |-> $past(state_reg) == S_MISS_OUT && out_valid_reg)
        else $error("insert without emitted prefix");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZW byte encoder. Bytes are fed as messages,
// codes are predicted by a software dictionary kept beside the block and
// compared in order as they leave it. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lzw_pkg::*;

    localparam int CODE_CAP = 512;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } code_word_t;

    typedef struct {
        logic [SYM_W-1:0]  sym;
        logic              eom;
        int                n_exp;
        logic [CODE_W-1:0] c0;
        logic              l0;
        logic [CODE_W-1:0] c1;
        logic              l1;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [SYM_W-1:0]  symbol;
    logic              end_of_message;
    logic              out_valid;
    logic              out_stall;
    logic [CODE_W-1:0] code;
    logic              last_code;

    // Predictor state
    logic [CODE_W-1:0] pfx_code;
    logic              pfx_held;
    logic [NFC_W-1:0]  free_code;
    logic [19:0]       pair_store [0:CODE_CAP-1];

    code_word_t        code_fifo [$];
    int                pushed_total;
    int                err_count;
    int                idle_cycles;
    bit                stim_done;
    bit                long_hold;

    lzw_byte_encoder #(.DICT_SIZE(CODE_CAP)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol         (symbol),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .code           (code),
        .last_code      (last_code)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Append one predicted code
    function automatic void enqueue_code(input logic [CODE_W-1:0] c, input logic l);
        code_word_t w;
        w.code = c;
        w.last = l;
        code_fifo = {code_fifo, w};
        pushed_total++;
    endfunction

    // Work out the codes caused by one accepted byte
    function automatic void predict_codes(input logic [SYM_W-1:0] sym, input logic eom);
        bit                found;
        logic [CODE_W-1:0] hit;
        found = 1'b0;
        hit = '0;
        if (!pfx_held)
        begin
            pfx_code = CODE_W'(sym);
            pfx_held = 1'b1;
        end
        else
        begin
            for (int c = 256; c < free_code; c++)
            begin
                if (!found && pair_store[c] == {pfx_code, sym})
                begin
                    found = 1'b1;
                    hit = CODE_W'(c);
                end
            end
            if (found)
                pfx_code = hit;
            else
            begin
                enqueue_code(pfx_code, 1'b0);
                if (free_code < CODE_CAP)
                begin
                    pair_store[free_code] = {pfx_code, sym};
                    free_code = free_code + 1'b1;
                end
                pfx_code = CODE_W'(sym);
            end
        end
        if (eom)
        begin
            enqueue_code(pfx_code, 1'b1);
            pfx_code = '0;
            pfx_held = 1'b0;
            free_code = FIRST_FREE;
        end
    endfunction

    // Offer one byte and wait for its transfer
    task automatic send_byte(input logic [SYM_W-1:0] sym, input logic eom);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        symbol         <= sym;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_codes(sym, eom);
    endtask

    // Directed check of the expected codes typed into a row
    function automatic void check_row(input stim_row_t r, input int n_new);
        code_word_t w;
        int         base;
        base = code_fifo.size() - n_new;
        if (n_new != r.n_exp)
        begin
            err_count++;
            if (err_count <= 10)
                $display("ERROR: table row count exp %0d got %0d", r.n_exp, n_new);
        end
        else
        begin
            if (r.n_exp >= 1)
            begin
                w = code_fifo[base];
                if (w.code != r.c0 || w.last != r.l0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: table row predicts %0d/%0d, expected %0d/%0d",
                                 w.code, w.last, r.c0, r.l0);
                end
            end
            if (r.n_exp == 2)
            begin
                w = code_fifo[base + 1];
                if (w.code != r.c1 || w.last != r.l1)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: table row predicts %0d/%0d, expected %0d/%0d",
                                 w.code, w.last, r.c1, r.l1);
                end
            end
        end
    endfunction

    // Send a message of random bytes drawn from the range 0 to alpha
    task automatic send_message(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_byte(SYM_W'($urandom_range(0, alpha)), i == len - 1);
    endtask

    // Stimulus
    initial
    begin
        stim_row_t rows [0:12];
        int        p0;
        int        sent;
        int        len;
        in_valid       <= 1'b0;
        symbol         <= '0;
        end_of_message <= 1'b0;
        pfx_code  = '0;
        pfx_held  = 1'b0;
        free_code = FIRST_FREE;
        stim_done = 1'b0;
        pushed_total = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte messages at the extremes, then short repeats
        rows[0]  = '{8'h00, 1'b1, 1, 12'd0,   1'b1, 12'd0, 1'b0};
        rows[1]  = '{8'hFF, 1'b1, 1, 12'd255, 1'b1, 12'd0, 1'b0};
        rows[2]  = '{8'hAA, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[3]  = '{8'h55, 1'b1, 2, 12'd170, 1'b0, 12'd85, 1'b1};
        rows[4]  = '{8'h41, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[5]  = '{8'h41, 1'b0, 1, 12'd65,  1'b0, 12'd0, 1'b0};
        rows[6]  = '{8'h41, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[7]  = '{8'h41, 1'b1, 2, 12'd256, 1'b0, 12'd65, 1'b1};
        rows[8]  = '{8'h00, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[9]  = '{8'hFF, 1'b0, 1, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[10] = '{8'h00, 1'b0, 1, 12'd255, 1'b0, 12'd0, 1'b0};
        rows[11] = '{8'hFF, 1'b0, 0, 12'd0,   1'b0, 12'd0, 1'b0};
        rows[12] = '{8'h00, 1'b1, 2, 12'd256, 1'b0, 12'd0, 1'b1};
        foreach (rows[i])
        begin
            p0 = pushed_total;
            send_byte(rows[i].sym, 1'b0 ^ rows[i].eom);
            check_row(rows[i], pushed_total - p0);
        end

        // Sender pauses until every code has arrived
        in_valid <= 1'b0;
        while (code_fifo.size() != 0) @(posedge clk);
        @(posedge clk);

        // Long hold on the output while bytes keep coming
        long_hold = 1'b1;
        send_message(12, 3);
        long_hold = 1'b0;

        // One message long enough to fill and freeze the dictionary
        for (int i = 0; i < 320; i++)
            send_byte(SYM_W'($urandom), i == 319);

        // Random messages, mostly short, low-entropy for deep matches
        sent = 0;
        while (sent < 180)
        begin
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 4) == 0)
                send_message(len, 255);
            else
                send_message(len, $urandom_range(1, 3));
            sent += len;
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output side: random stalls, one long hold-off on request
    initial
    begin
        int wait_n;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare each transferred code with the oldest prediction
    always @(posedge clk)
    begin
        code_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (code_fifo.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: unexpected code %0d last %0d", code, last_code);
            end
            else
            begin
                w = code_fifo.pop_front();
                if (w.code !== code || w.last !== last_code)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: code exp %0d got %0d, last exp %0d got %0d",
                                 w.code, code, w.last, last_code);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // End of run
    initial
    begin
        err_count   = 0;
        idle_cycles = 0;
        long_hold   = 1'b0;
        wait (stim_done);
        while (code_fifo.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (err_count == 0 && code_fifo.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lzw_pkg.sv
rtl/core/lzw_ram.sv
rtl/core/lzw_byte_encoder.sv
test/tb_top.sv
